// ===== hdl/rc_pulse_width_stick_decoder_defines.svh =====
// Assertion macros shared by the stick decoder RTL
`ifndef RC_PULSE_WIDTH_STICK_DECODER_DEFINES_SVH
`define RC_PULSE_WIDTH_STICK_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCPWSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpwsd assertion failed");

// next-cycle implication, disabled during reset
`define RCPWSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpwsd assertion failed");

`endif

// ===== hdl/rcpwsd_pkg.sv =====
// Types, constants and control codes of the RC pulse width stick decoder
package rcpwsd_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int TS_W         = 32;
  localparam int WIDTH_W      = 16;
  localparam int REG_W        = 12;
  localparam int MAG_W        = 17;
  localparam int DIFF_W       = 18;
  localparam int MAG10_W      = 21;
  localparam int QUOT_W       = 15;
  localparam int STICK_W      = 16;
  localparam int DIV_STEPS    = 15;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX    = 16'hFFFF;
  localparam logic [REG_W-1:0]   CENTER_RESET = 12'd1500;
  localparam logic [REG_W-1:0]   SPAN_RESET   = 12'd400;
  localparam logic [STICK_W-1:0] Q_ONE        = 16'd16384;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_BASE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_END     = 4'd8;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            level;
    logic [TS_W-1:0] timestamp_us;
  } evt_t;

  typedef struct packed {
    logic [CH_W-1:0]           out_channel;
    logic [WIDTH_W-1:0]        pulse_width_us;
    logic signed [STICK_W-1:0] stick_value;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLASS,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic diff;
    logic classify;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic falling;
    logic skip_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/rc_pulse_width_stick_decoder.sv =====
// Rising edge event: stores the start time, no result.
// Falling edge event: passes DIFF, CLASS, DIV and FIN; the 15-step restoring divider
// forms the Q1.14 quotient in DIV, with no steps in the deadband or at full deflection.
// FIN waits for a free output; the next event is taken in the cycle the result appears.
// Synchronous reset: start times to 0, centers to 1500, spans to 400, no result.
module rc_pulse_width_stick_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             evt_valid,
  output logic                             evt_ready,
  input  rcpwsd_pkg::evt_t                 evt,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rcpwsd_pkg::res_t                 res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcpwsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcpwsd_pkg::REG_W-1:0]     cfg_data
);
  import rcpwsd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rcpwsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rcpwsd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== hdl/rcpwsd_datapath.sv =====
// Datapath: start times, config registers, normalizer, serial divider, result register
`include "rc_pulse_width_stick_decoder_defines.svh"

module rcpwsd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rcpwsd_pkg::evt_t                    evt,
  input  logic                                cfg_valid,
  input  logic [rcpwsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcpwsd_pkg::REG_W-1:0]        cfg_data,
  input  rcpwsd_pkg::dp_cmd_t                 cmd,
  output rcpwsd_pkg::dp_sts_t                 sts,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rcpwsd_pkg::res_t                    res
);
  import rcpwsd_pkg::*;

  logic [TS_W-1:0]    start_time [NUM_CHANNELS];
  logic [REG_W-1:0]   center     [NUM_CHANNELS];
  logic [REG_W-1:0]   span       [NUM_CHANNELS];

  logic [CH_W-1:0]    ch;
  logic [WIDTH_W-1:0] width;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [REG_W-1:0]   sp;
  logic               dead;
  logic               full;
  logic [REG_W-1:0]   rem;
  logic [QUOT_W-1:0]  quot;
  logic [CNT_W-1:0]   cnt;

  logic [TS_W-1:0]    elapsed;
  logic [WIDTH_W-1:0] width_sat;
  logic [DIFF_W-1:0]  d;
  logic [MAG_W-1:0]   mag_abs;
  logic [REG_W-1:0]   sp_sel;
  logic [MAG10_W-1:0] mag10;
  logic [REG_W:0]     shifted;
  logic               ge;
  logic [WIDTH_W-1:0] rounded;
  logic [STICK_W-1:0] q;

  assign elapsed   = evt.timestamp_us - start_time[evt.channel];
  assign width_sat = (|elapsed[TS_W-1:WIDTH_W]) ? WIDTH_MAX : elapsed[WIDTH_W-1:0];

  assign d       = {{(DIFF_W-WIDTH_W){1'b0}}, width} - {{(DIFF_W-REG_W){1'b0}}, center[ch]};
  assign mag_abs = d[DIFF_W-1] ? MAG_W'(-d) : d[MAG_W-1:0];
  assign sp_sel  = (span[ch] == '0) ? REG_W'(1) : span[ch];

  assign mag10   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, sp};

  assign rounded = ({1'b0, quot} + WIDTH_W'(1)) >> 1;
  assign q       = dead ? '0 : (full ? Q_ONE : rounded);

  assign sts.falling  = ~evt.level;
  assign sts.skip_div = dead | full;
  assign sts.div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign sts.out_free = ~res_valid | res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_time[i] <= '0;
        center[i]     <= CENTER_RESET;
        span[i]       <= SPAN_RESET;
      end
      res_valid <= 1'b0;
      dead      <= 1'b0;
      full      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index < CFG_SPAN_BASE) begin
          center[cfg_index[CH_W-1:0] - CFG_CENTER_BASE[CH_W-1:0]] <= cfg_data;
        end else if (cfg_index < CFG_REG_END) begin
          span[cfg_index[CH_W-1:0] - CFG_SPAN_BASE[CH_W-1:0]] <= cfg_data;
        end
      end
      if (cmd.take && evt.level) begin
        start_time[evt.channel] <= evt.timestamp_us;
      end
      if (cmd.classify) begin
        dead <= mag10 < {{(MAG10_W-REG_W){1'b0}}, sp};
        full <= mag >= {{(MAG_W-REG_W){1'b0}}, sp};
        cnt  <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch    <= evt.channel;
      width <= width_sat;
    end
    if (cmd.diff) begin
      mag <= mag_abs;
      neg <= d[DIFF_W-1];
      sp  <= sp_sel;
    end
    if (cmd.classify) begin
      rem  <= mag[REG_W-1:0];
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? REG_W'(shifted - {1'b0, sp}) : shifted[REG_W-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
    end
    if (cmd.emit) begin
      res.out_channel    <= ch;
      res.pulse_width_us <= width;
      res.stick_value    <= neg ? STICK_W'(-q) : q;
    end
  end

  `RCPWSD_ASSERT_NOW(a_stick_range, clk, rst, res_valid,
    (res.stick_value <= $signed(Q_ONE)) && (res.stick_value >= -$signed(Q_ONE)))
  `RCPWSD_ASSERT_NOW(a_dead_not_full, clk, rst, dead, !full)
  `RCPWSD_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, res_valid)

endmodule

// ===== hdl/rcpwsd_ctrl.sv =====
// Controller state machine sequencing one edge event through the datapath
`include "rc_pulse_width_stick_decoder_defines.svh"

module rcpwsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  output rcpwsd_pkg::dp_cmd_t cmd,
  input  rcpwsd_pkg::dp_sts_t sts
);
  import rcpwsd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    evt_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          cmd.take = 1'b1;
          if (sts.falling) begin
            state_next = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (sts.skip_div) begin
          state_next = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RCPWSD_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, sts.out_free)
  `RCPWSD_ASSERT_NEXT(a_div_exit, clk, rst,
    (state == ST_DIV) && sts.div_last && !sts.skip_div, state == ST_FIN)
  `RCPWSD_ASSERT_NEXT(a_fall_start, clk, rst,
    evt_valid && evt_ready && sts.falling, state == ST_DIFF)

endmodule

// ===== bench/rc_pulse_width_stick_decoder_test.sv =====
// Self-checking testbench for the RC pulse width stick decoder
module rc_pulse_width_stick_decoder_test;
  import rcpwsd_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int SETTLE_CYC  = 30;
  localparam int NUM_PHASES  = 8;
  localparam int GROUPS      = 82;

  class stick_scoreboard;
    logic [TS_W-1:0]  start_ts [NUM_CHANNELS];
    logic [REG_W-1:0] center   [NUM_CHANNELS];
    logic [REG_W-1:0] span     [NUM_CHANNELS];
    res_t             pending_pulses [$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_ts[i] = '0;
        center[i]   = CENTER_RESET;
        span[i]     = SPAN_RESET;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx < CFG_SPAN_BASE) begin
        center[CH_W'(idx - CFG_CENTER_BASE)] = val;
      end else if (idx < CFG_REG_END) begin
        span[CH_W'(idx - CFG_SPAN_BASE)] = val;
      end
    endfunction

    function logic signed [STICK_W-1:0] stick_of(logic [WIDTH_W-1:0] w,
                                                 logic [REG_W-1:0] c,
                                                 logic [REG_W-1:0] s);
      int dev, mag, sp, q;
      dev = int'(w) - int'(c);
      mag = (dev < 0) ? -dev : dev;
      sp  = (s == '0) ? 1 : int'(s);
      if (mag * 10 < sp) begin
        q = 0;
      end else if (mag >= sp) begin
        q = int'(Q_ONE);
      end else begin
        q = (mag * 2 * int'(Q_ONE) / sp + 1) / 2;
      end
      return (dev < 0) ? STICK_W'(-q) : STICK_W'(q);
    endfunction

    function void note_event(evt_t e);
      logic [TS_W-1:0] elapsed;
      res_t            r;
      if (e.level) begin
        start_ts[e.channel] = e.timestamp_us;
      end else begin
        elapsed = e.timestamp_us - start_ts[e.channel];
        r.out_channel    = e.channel;
        r.pulse_width_us = (elapsed > TS_W'(WIDTH_MAX)) ? WIDTH_MAX : elapsed[WIDTH_W-1:0];
        r.stick_value    = stick_of(r.pulse_width_us, center[e.channel], span[e.channel]);
        pending_pulses.push_back(r);
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (errors < 40) begin
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_pulses.size() == 0) begin
        report_mismatch("unexpected result on channel", got.out_channel, -1);
      end else begin
        want = pending_pulses.pop_front();
        if (got.out_channel != want.out_channel)
          report_mismatch("out_channel", got.out_channel, want.out_channel);
        if (got.pulse_width_us != want.pulse_width_us)
          report_mismatch("pulse_width_us", got.pulse_width_us, want.pulse_width_us);
        if (got.stick_value != want.stick_value)
          report_mismatch("stick_value", got.stick_value, want.stick_value);
      end
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_ready;
  evt_t                 evt       = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_t                 res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  stick_scoreboard sb;
  bit              idle_on = 1'b1;
  int              stuck_cycles = 0;

  rc_pulse_width_stick_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (evt_valid && evt_ready) sb.note_event(evt);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_valid && evt_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("rc_pulse_width_stick_decoder verification failed");
        $finish;
      end
    end
  end

  // result side: stall lands once a result is waiting
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        res_ready <= 1'b0;
        do @(posedge clk); while (!res_valid);
        repeat (stall - 1) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  task automatic send_evt(logic [CH_W-1:0] ch, logic lvl, logic [TS_W-1:0] ts);
    int   gap;
    evt_t e;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    e.channel      = ch;
    e.level        = lvl;
    e.timestamp_us = ts;
    if (gap != 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    do @(posedge clk); while (!evt_ready);
  endtask

  task automatic send_pulse(logic [CH_W-1:0] ch, logic [TS_W-1:0] t0, logic [TS_W-1:0] w);
    send_evt(ch, 1'b1, t0);
    send_evt(ch, 1'b0, t0 + w);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop valid, wait for every pending result, then let the divider go quiet
  task automatic settle();
    evt_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_pulses.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [TS_W-1:0] pick_width(logic [CH_W-1:0] ch);
    int c, sp, dev, lim;
    c   = int'(sb.center[ch]);
    sp  = (sb.span[ch] == '0) ? 1 : int'(sb.span[ch]);
    dev = 0;
    case ($urandom_range(0, 7))
      0: begin
        lim = sp / 10 + 1;
        dev = int'($urandom_range(0, 2 * lim)) - lim;
      end
      1, 2: dev = int'($urandom_range(0, 2 * sp)) - sp;
      3: dev = sp + int'($urandom_range(0, 300));
      4: dev = sp - int'($urandom_range(0, 1));
      5: dev = (sp + 9) / 10 - int'($urandom_range(0, 1));
      6: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 1) ? 32'd65535 + $urandom_range(0, 1) : $urandom();
    endcase
    if ($urandom_range(0, 1)) dev = -dev;
    return TS_W'(c + dev);
  endfunction

  task automatic run_directed();
    send_evt(2'd0, 1'b0, 32'd1500);
    send_evt(2'd1, 1'b0, 32'hFFFF_FFFF);
    send_pulse(2'd2, 32'hFFFF_FE00, 32'd1900);
    send_pulse(2'd3, 32'd100, 32'd0);
    send_pulse(2'd0, 32'd1000, 32'd1540);
    send_pulse(2'd1, 32'd7, 32'd1539);
    send_pulse(2'd2, 32'h8000_0000, 32'd1460);
    send_pulse(2'd3, 32'h5555_5555, 32'd1700);
    send_pulse(2'd0, 32'hAAAA_AAAA, 32'd1100);
    send_pulse(2'd1, 32'd0, 32'd1899);
    send_evt(2'd2, 1'b1, 32'd10);
    send_pulse(2'd2, 32'd20, 32'd65535);
    send_pulse(2'd3, 32'd30, 32'd65536);
  endtask

  task automatic program_phase(int ph);
    logic [REG_W-1:0] c, s;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      case (ph)
        1: begin
          c = '0;
          s = 12'd1;
        end
        2: begin
          c = '1;
          s = '1;
        end
        3: begin
          c = REG_W'($urandom_range(1000, 2000));
          s = '0;
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            c = REG_W'($urandom_range(1000, 2000));
            s = REG_W'($urandom_range(100, 800));
          end else begin
            c = REG_W'($urandom_range(0, 4095));
            s = REG_W'($urandom_range(0, 4095));
          end
        end
      endcase
      write_cfg(CFG_IDX_W'(CFG_CENTER_BASE + ch), c);
      write_cfg(CFG_IDX_W'(CFG_SPAN_BASE + ch), s);
    end
    if (ph >= 3) begin
      write_cfg(CFG_IDX_W'(CFG_REG_END + $urandom_range(0, 7)), REG_W'($urandom_range(0, 4095)));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_group();
    int               kind;
    logic [CH_W-1:0]  a, b;
    logic [TS_W-1:0]  t0, t1;
    kind = $urandom_range(0, 99);
    a    = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    b    = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    t0   = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
    t1   = t0 + $urandom_range(0, 2000);
    if (kind < 60) begin
      send_pulse(a, t0, pick_width(a));
    end else if (kind < 80) begin
      send_evt(a, 1'b1, t0);
      send_evt(b, 1'b1, t1);
      send_evt(a, 1'b0, t0 + pick_width(a));
      send_evt(b, 1'b0, t1 + pick_width(b));
    end else if (kind < 90) begin
      send_evt(a, 1'b0, $urandom());
    end else begin
      send_evt(a, 1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  initial begin
    int hold_at;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        program_phase(ph);
      end
      idle_on = (ph % 3) != 2;
      hold_at = $urandom_range(5, GROUPS - 10);
      for (int g = 0; g < GROUPS; g++) begin
        if (g == hold_at) settle();
        random_group();
      end
    end
    settle();
    if (sb.errors == 0) begin
      $display("rc_pulse_width_stick_decoder verification clean");
    end else begin
      $display("rc_pulse_width_stick_decoder verification failed");
    end
    $finish;
  end

endmodule
